@@ rtl/swmms_pkg.sv @@
// ----------------------------------------------------------------------------
// swmms_pkg
// Shared sizes, types and register codes for the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmms_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 32;

   localparam int IDX_W  = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SIZE_W = 7;
   localparam int SUM_W  = SAMPLE_BITS + 1;
   localparam int ACC_W  = 64;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_SIZE = CSR_ADDR_W'(0);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]       pair_sum_type;
   typedef logic signed [ACC_W-1:0]       total_type;

   // per-request tag that rides along the pipeline
   typedef struct packed {
      logic last;
      logic full;
   } swmms_tag_type;

   // window length to cell index: zero acts as one, large sizes clamp
   function automatic logic [IDX_W-1:0] size_to_index(input logic [SIZE_W-1:0] size);
      int k;
      k = int'(size);
      if (k == 0) begin
         k = 1;
      end
      if (k > MAX_WINDOW) begin
         k = MAX_WINDOW;
      end
      return IDX_W'(k - 1);
   endfunction

endpackage

@@ rtl/swmms_cell.sv @@
// ----------------------------------------------------------------------------
// swmms_cell
// One cell of the min/max chain: holds the min and max of the newest samples
// over a span one longer than its left neighbor.
// ----------------------------------------------------------------------------
module swmms_cell
   import swmms_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  sample_type sample,
   input  sample_type prev_min,
   input  sample_type prev_max,
   output sample_type cell_min,
   output sample_type cell_max
);

   sample_type min_ff;
   sample_type max_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         min_ff <= (prev_min < sample) ? prev_min : sample;
         max_ff <= (prev_max > sample) ? prev_max : sample;
      end
   end

   assign cell_min = min_ff;
   assign cell_max = max_ff;

endmodule

@@ rtl/swmms_window.sv @@
// ----------------------------------------------------------------------------
// swmms_window
// Chain of min/max cells and the registered tap select for the window length.
// ----------------------------------------------------------------------------
module swmms_window
   import swmms_pkg::*;
(
   input  logic              clock,
   input  logic              shift_en,
   input  sample_type        sample,
   input  logic              load_en,
   input  logic [IDX_W-1:0]  sel_idx,
   input  logic              full,
   output sample_type        win_min,
   output sample_type        win_max,
   output pair_sum_type      pair_sum
);

   sample_type min_chain [MAX_WINDOW];
   sample_type max_chain [MAX_WINDOW];

   sample_type   min_ff;
   sample_type   max_ff;
   pair_sum_type sum_ff;
   sample_type   tap_min;
   sample_type   tap_max;

   genvar j;
   generate
      for (j = 0; j < MAX_WINDOW; j++) begin : g_cell
         if (j == 0) begin : g_head
            swmms_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .sample   (sample),
               .prev_min (sample),
               .prev_max (sample),
               .cell_min (min_chain[j]),
               .cell_max (max_chain[j])
            );
         end else begin : g_body
            swmms_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .sample   (sample),
               .prev_min (min_chain[j-1]),
               .prev_max (max_chain[j-1]),
               .cell_min (min_chain[j]),
               .cell_max (max_chain[j])
            );
         end
      end
   endgenerate

   assign tap_min = min_chain[sel_idx];
   assign tap_max = max_chain[sel_idx];

   always_ff @(posedge clock) begin
      if (load_en) begin
         if (full) begin
            min_ff <= tap_min;
            max_ff <= tap_max;
            sum_ff <= SUM_W'(tap_min) + SUM_W'(tap_max);
         end else begin
            min_ff <= '0;
            max_ff <= '0;
            sum_ff <= '0;
         end
      end
   end

   assign win_min  = min_ff;
   assign win_max  = max_ff;
   assign pair_sum = sum_ff;

endmodule

@@ rtl/swmms_accum.sv @@
// ----------------------------------------------------------------------------
// swmms_accum
// Saturating running total and the output register of the response channel.
// ----------------------------------------------------------------------------
module swmms_accum
   import swmms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  swmms_tag_type in_tag,
   input  sample_type    in_min,
   input  sample_type    in_max,
   input  pair_sum_type  in_sum,
   output logic          out_valid,
   input  logic          out_ready,
   output sample_type    out_min,
   output sample_type    out_max,
   output total_type     out_total,
   output logic          out_saturated,
   output logic          out_short,
   output logic          out_final
);

   localparam total_type TOTAL_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam total_type TOTAL_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic                    valid_ff;
   total_type               acc_ff;
   logic                    clamp_ff;
   sample_type              min_ff;
   sample_type              max_ff;
   total_type               total_ff;
   logic                    sat_ff;
   logic                    short_ff;
   logic                    final_ff;

   logic signed [ACC_W:0]   wide_sum;
   total_type               acc_in;
   logic                    clamp_in;
   logic                    take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      wide_sum = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(in_sum);
      acc_in   = acc_ff;
      clamp_in = clamp_ff;
      if (in_tag.full) begin
         // overflow when the two top bits disagree
         if (wide_sum[ACC_W] != wide_sum[ACC_W-1]) begin
            acc_in   = wide_sum[ACC_W] ? TOTAL_MIN : TOTAL_MAX;
            clamp_in = 1'b1;
         end else begin
            acc_in = wide_sum[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
         clamp_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            if (in_tag.last) begin
               acc_ff   <= '0;
               clamp_ff <= 1'b0;
            end else begin
               acc_ff   <= acc_in;
               clamp_ff <= clamp_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         min_ff   <= in_min;
         max_ff   <= in_max;
         total_ff <= acc_in;
         sat_ff   <= clamp_in;
         short_ff <= !in_tag.full;
         final_ff <= in_tag.last;
      end
   end

   assign out_valid     = valid_ff;
   assign out_min       = min_ff;
   assign out_max       = max_ff;
   assign out_total     = total_ff;
   assign out_saturated = sat_ff;
   assign out_short     = short_ff;
   assign out_final     = final_ff;

endmodule

@@ rtl/sliding_window_min_max_sum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_min_max_sum
// Sliding window minimum and maximum with a saturating running total.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one signed sample per request, tlast marks the last
//   sample of a sequence. rsp channel returns min, max and the running total
//   once the window is full, and always on the last sample (tlast on rsp).
//   A last sample that arrives before the window filled gives a short result
//   (tuser bit 1) with zero min and max.
//   window_size is set through the csr port at byte address 0 while idle.
//   Throughput is one request per cycle while rsp does not stall; each min/max
//   chain cell compares for min and for max on every request taken. A result
//   reaches rsp via the request stage, the window tap select, then the accumulator.
//   Reset clears the sequence state and sets window_size to one; the sample
//   cells need no clearing. When rsp stalls, the three stages keep filling
//   and req_tready drops only once all of them hold a result.
// ----------------------------------------------------------------------------
module sliding_window_min_max_sum
   import swmms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] sample
   input  logic                  req_tlast,   // seq_end

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,   // [31:0] window_min, [63:32] window_max,
                                              // [127:64] running_total
   output logic [1:0]            rsp_tuser,   // [0] total_saturated, [1] short_sequence
   output logic                  rsp_tlast,   // is_final

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SIZE_W-1:0] window_size_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;
   logic              a_valid_ff;
   swmms_tag_type     a_tag_ff;
   logic [IDX_W-1:0]  a_idx_ff;
   logic              b_valid_ff;
   swmms_tag_type     b_tag_ff;

   logic              a_ready;
   logic              b_ready;
   logic              c_ready;
   logic              accept;
   logic [IDX_W-1:0]  cur_idx;
   logic              cur_full;

   sample_type        sample;
   sample_type        b_min;
   sample_type        b_max;
   pair_sum_type      b_sum;
   sample_type        out_min;
   sample_type        out_max;
   total_type         out_total;

   // configuration port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= SIZE_W'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == REG_WINDOW_SIZE) begin
         window_size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr)
         REG_WINDOW_SIZE: csr_prdata = CSR_DATA_W'(window_size_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // pipeline handshake
   assign b_ready    = !b_valid_ff || c_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign accept     = req_tvalid && req_tready;

   assign sample  = req_tdata[SAMPLE_BITS-1:0];
   assign cur_idx = size_to_index(window_size_ff);
   assign fill_in = (int'(fill_ff) < MAX_WINDOW) ? fill_ff + CNT_W'(1) : fill_ff;
   assign cur_full = int'(fill_in) > int'(cur_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= req_tlast ? '0 : fill_in;
         end
         if (a_ready) begin
            // requests with neither a full window nor an end give no result
            a_valid_ff <= accept && (cur_full || req_tlast);
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_tag_ff.last <= req_tlast;
         a_tag_ff.full <= cur_full;
         a_idx_ff      <= cur_idx;
      end
      if (b_ready && a_valid_ff) begin
         b_tag_ff <= a_tag_ff;
      end
   end

   swmms_window u_window (
      .clock    (clock),
      .shift_en (accept),
      .sample   (sample),
      .load_en  (b_ready && a_valid_ff),
      .sel_idx  (a_idx_ff),
      .full     (a_tag_ff.full),
      .win_min  (b_min),
      .win_max  (b_max),
      .pair_sum (b_sum)
   );

   swmms_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (b_valid_ff),
      .in_ready      (c_ready),
      .in_tag        (b_tag_ff),
      .in_min        (b_min),
      .in_max        (b_max),
      .in_sum        (b_sum),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_min       (out_min),
      .out_max       (out_max),
      .out_total     (out_total),
      .out_saturated (rsp_tuser[0]),
      .out_short     (rsp_tuser[1]),
      .out_final     (rsp_tlast)
   );

   assign rsp_tdata = {out_total, 32'(out_max), 32'(out_min)};

endmodule
